// ===== sv/memory_key_region_table_unit_defines.svh =====
// Assertion macros for the memory key region table unit.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MEMORY_KEY_REGION_TABLE_UNIT_DEFINES_SVH
`define MEMORY_KEY_REGION_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication under reset.
`define MKRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mkrt: assertion failed");

// Next-cycle implication under reset.
`define MKRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mkrt: assertion failed");

`else

`define MKRT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MKRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/mkrt_pkg.sv =====
// Types and constants of the memory key region table unit.
// No dependencies; imported by mkrt_alu and the top-level module.
package mkrt_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [SLOT_W:0]   t_scan;

    localparam logic [32:0] KEY_LIMIT = 33'h0_FFFF_FFFE;

    typedef enum logic [1:0] {
        OP_REG   = 2'd0,
        OP_DEREG = 2'd1,
        OP_RES   = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_DENIED  = 3'd3,
        ST_PROTO   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_ARITH,
        S_WRITE,
        S_DONE
    } t_state;

    // Range check steps of a resolve, one pass of the shared adder each
    typedef enum logic [2:0] {
        AS_OFF,
        AS_AEND,
        AS_REND,
        AS_FIT,
        AS_XLAT
    } t_astep;

    localparam logic [1:0] ACC_LOCAL  = 2'b01;
    localparam logic [1:0] ACC_REMOTE = 2'b10;

    typedef struct packed {
        logic [15:0] domain;
        logic [63:0] base;
        logic [63:0] len;
        logic [63:0] tgt;
        logic [1:0]  acc;
        logic [31:0] lkey;
        logic [31:0] rkey;
    } t_entry;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic        sub;
    } t_alu_req;

    typedef struct packed {
        logic [63:0] sum;
        logic        carry;
    } t_alu_rsp;

    typedef struct packed {
        t_status     status;
        logic [3:0]  slot;
        logic [31:0] lkey;
        logic [31:0] rkey;
        logic [63:0] xaddr;
    } t_result;

endpackage

// ===== sv/mkrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the region entries of the key table.
module mkrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/mkrt_alu.sv =====
// Shared 64-bit add/subtract unit with carry out, used for all range checks.
// Depends on mkrt_pkg for the request and response types.
module mkrt_alu
    import mkrt_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [63:0] w_b;
    logic [64:0] w_sum;

    // Subtract as a + ~b + 1; carry set means no borrow
    assign w_b   = i_req.sub ? ~i_req.b : i_req.b;
    assign w_sum = {1'b0, i_req.a} + {1'b0, w_b} + {64'd0, i_req.sub};

    assign o_rsp.sum   = w_sum[63:0];
    assign o_rsp.carry = w_sum[64];

endmodule

// ===== sv/memory_key_region_table_unit.sv =====
// Top level of the memory key region table: sequencer, slot valid bits, key counter.
// Depends on mkrt_pkg, mkrt_ram, mkrt_alu and memory_key_region_table_unit_defines.svh.
//
// Usage:
// An input word (opcode, domain, address, length, target base, access bits,
// key, remote flag, slot) is taken when i_in_valid is high and o_in_stall low.
// Each word yields one result word (status, slot index, two keys, translated
// address) on o_out_valid, taken when i_out_stall is low. The key counter is
// loaded through the config channel (i_cfg_valid / o_cfg_ready / i_cfg_data)
// while the block is idle.
// Deregister and early rejects pass through the check step straight to the
// done step. Register scans up to SLOTS entries through the one RAM read port,
// one per cycle, and stops early on a duplicate key. Resolve scans up to SLOTS
// entries, then runs five range checks through the shared 64-bit adder, one a
// cycle, stopping at the first failure. One word is in work at a time.
// A finished result sits in the output register; the next input word is
// taken while it waits, and a stalled receiver holds it there unchanged.
// Reset clears all slot valid bits at once and sets the key counter to 1.
`include "memory_key_region_table_unit_defines.svh"

module memory_key_region_table_unit
    import mkrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_domain_id,
    input  logic [63:0] i_address,
    input  logic [63:0] i_length,
    input  logic [63:0] i_target_base,
    input  logic [1:0]  i_access_flags,
    input  logic [31:0] i_key,
    input  logic        i_remote,
    input  logic [3:0]  i_slot,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [3:0]  o_slot_index,
    output logic [31:0] o_local_key_out,
    output logic [31:0] o_remote_key_out,
    output logic [63:0] o_translated_address,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    // Control state
    t_state          r_state, n_state;
    logic [SLOTS-1:0] r_valid, n_valid;
    logic [32:0]     r_cnt, n_cnt;
    t_scan           r_idx, n_idx;
    logic            r_chk, n_chk;
    t_slot           r_chk_idx, n_chk_idx;
    logic            r_has_free, n_has_free;
    t_slot           r_free, n_free;
    t_astep          r_step, n_step;
    logic            r_out_valid, n_out_valid;

    // Payload
    logic [1:0]  r_opcode, n_opcode;
    logic [15:0] r_dom, n_dom;
    logic [63:0] r_addr, n_addr;
    logic [63:0] r_len, n_len;
    logic [63:0] r_tgt, n_tgt;
    logic [1:0]  r_acc, n_acc;
    logic [31:0] r_key, n_key;
    logic        r_remote, n_remote;
    logic [3:0]  r_slot, n_slot;
    logic [31:0] r_lk, n_lk;
    logic [31:0] r_rk, n_rk;
    logic [63:0] r_base, n_base;
    logic [63:0] r_mlen, n_mlen;
    logic [63:0] r_xtgt, n_xtgt;
    logic [63:0] r_off, n_off;
    logic [63:0] r_aend, n_aend;
    logic [63:0] r_rend, n_rend;
    t_result     r_res, n_res;
    t_result     r_out, n_out;

    logic        w_accept;
    logic        w_cfg_wr;
    logic        w_out_free;
    logic [32:0] w_cnt_p1;
    logic [32:0] w_cnt_p2;
    logic        w_reg_bad;
    logic        w_reg_empty;
    logic        w_reg_proto;
    logic        w_key_exh;
    logic        w_res_bad;
    t_slot       w_dsl;
    logic        w_dslot_ok;
    logic        w_issue;
    t_entry      w_rd;
    t_entry      w_wr;
    logic        w_ram_we;
    logic        w_chk_valid;
    logic        w_dom_eq;
    logic        w_dup;
    logic        w_hit;
    logic        w_last;
    logic        w_free_now;
    logic        w_denied;
    t_alu_req    w_alu_req;
    t_alu_rsp    w_alu_rsp;
    logic        w_step_fail;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_cfg_wr   = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    assign w_cnt_p1 = r_cnt + 33'd1;
    assign w_cnt_p2 = r_cnt + 33'd2;

    assign w_reg_bad   = (r_acc == ACC_REMOTE);
    assign w_reg_empty = (r_addr == 64'd0) || (r_len == 64'd0);
    assign w_reg_proto = (r_tgt == 64'd0);
    assign w_key_exh   = (r_cnt == 33'd0) || (r_cnt > KEY_LIMIT);
    assign w_res_bad   = (r_key == 32'd0) || (r_len == 64'd0);

    assign w_dsl      = t_slot'(r_slot);
    assign w_dslot_ok = (32'(r_slot) < SLOTS) && r_valid[w_dsl];

    // Scan: issue one RAM read a cycle, check the word read the cycle before
    assign w_issue     = (r_state == S_SCAN) && (r_idx < t_scan'(SLOTS));
    assign w_chk_valid = r_valid[r_chk_idx];
    assign w_dom_eq    = (w_rd.domain == r_dom);
    assign w_dup       = r_chk && w_chk_valid && w_dom_eq &&
                         ((w_rd.lkey == r_lk) || (w_rd.rkey == r_rk));
    assign w_hit       = r_chk && w_chk_valid && w_dom_eq &&
                         ((r_remote ? w_rd.rkey : w_rd.lkey) == r_key);
    assign w_last      = r_chk && (r_chk_idx == t_slot'(SLOTS - 1));
    assign w_free_now  = r_chk && !w_chk_valid && !r_has_free;
    assign w_denied    = r_remote && ((w_rd.acc & ACC_REMOTE) == 2'b00);

    assign w_wr.domain = r_dom;
    assign w_wr.base   = r_addr;
    assign w_wr.len    = r_len;
    assign w_wr.tgt    = r_tgt;
    assign w_wr.acc    = r_acc;
    assign w_wr.lkey   = r_lk;
    assign w_wr.rkey   = r_rk;
    assign w_ram_we    = (r_state == S_WRITE);

    mkrt_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_ram_we),
        .i_wr_addr(r_free),
        .i_wr_data(w_wr),
        .i_rd_en  (w_issue),
        .i_rd_addr(r_idx[SLOT_W-1:0]),
        .o_rd_data(w_rd)
    );

    // Operand selection for the shared adder
    always_comb begin
        w_alu_req.a   = r_addr;
        w_alu_req.b   = r_base;
        w_alu_req.sub = 1'b1;
        case (r_step)
            AS_AEND: begin
                w_alu_req.b   = r_len;
                w_alu_req.sub = 1'b0;
            end
            AS_REND: begin
                w_alu_req.a   = r_base;
                w_alu_req.b   = r_mlen;
                w_alu_req.sub = 1'b0;
            end
            AS_FIT: begin
                w_alu_req.a = r_rend;
                w_alu_req.b = r_aend;
            end
            AS_XLAT: begin
                w_alu_req.a   = r_xtgt;
                w_alu_req.b   = r_off;
                w_alu_req.sub = 1'b0;
            end
            default: begin
                w_alu_req.sub = 1'b1;
            end
        endcase
    end

    // A borrow on a subtract step or a carry on an add step fails the range check
    always_comb begin
        case (r_step)
            AS_OFF: begin
                w_step_fail = !w_alu_rsp.carry;
            end
            AS_AEND: begin
                w_step_fail = w_alu_rsp.carry;
            end
            AS_REND: begin
                w_step_fail = w_alu_rsp.carry;
            end
            AS_FIT: begin
                w_step_fail = !w_alu_rsp.carry;
            end
            AS_XLAT: begin
                w_step_fail = w_alu_rsp.carry;
            end
            default: begin
                w_step_fail = 1'b1;
            end
        endcase
    end

    mkrt_alu u_alu (
        .i_req(w_alu_req),
        .o_rsp(w_alu_rsp)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                unique case (r_opcode)
                    OP_REG: begin
                        if (w_reg_bad || w_reg_empty || w_reg_proto || w_key_exh) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_RES: begin
                        n_state = w_res_bad ? S_DONE : S_SCAN;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_opcode == OP_REG) begin
                    if (w_dup) begin
                        n_state = S_DONE;
                    end else if (w_last) begin
                        n_state = (r_has_free || w_free_now) ? S_WRITE : S_DONE;
                    end
                end else begin
                    if (w_hit) begin
                        n_state = w_denied ? S_DONE : S_ARITH;
                    end else if (w_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ARITH: begin
                if (w_step_fail || (r_step == AS_XLAT)) begin
                    n_state = S_DONE;
                end
            end
            S_WRITE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and result
    always_comb begin
        n_valid     = r_valid;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_chk       = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_has_free  = r_has_free;
        n_free      = r_free;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_opcode    = r_opcode;
        n_dom       = r_dom;
        n_addr      = r_addr;
        n_len       = r_len;
        n_tgt       = r_tgt;
        n_acc       = r_acc;
        n_key       = r_key;
        n_remote    = r_remote;
        n_slot      = r_slot;
        n_lk        = r_lk;
        n_rk        = r_rk;
        n_base      = r_base;
        n_mlen      = r_mlen;
        n_xtgt      = r_xtgt;
        n_off       = r_off;
        n_aend      = r_aend;
        n_rend      = r_rend;
        n_res       = r_res;
        n_out       = r_out;

        // Drop the output word once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_opcode = i_opcode;
                    n_dom    = i_domain_id;
                    n_addr   = i_address;
                    n_len    = i_length;
                    n_tgt    = i_target_base;
                    n_acc    = i_access_flags;
                    n_key    = i_key;
                    n_remote = i_remote;
                    n_slot   = i_slot;
                    n_res    = '0;
                end
            end
            S_CHECK: begin
                n_idx      = '0;
                n_has_free = 1'b0;
                n_step     = AS_OFF;
                unique case (r_opcode)
                    OP_REG: begin
                        if (w_reg_bad || w_reg_empty) begin
                            n_res.status = ST_INVALID;
                        end else if (w_reg_proto) begin
                            n_res.status = ST_PROTO;
                        end else if (w_key_exh) begin
                            n_res.status = ST_NOSPACE;
                        end else begin
                            n_lk  = r_cnt[31:0];
                            n_rk  = w_cnt_p1[31:0];
                            n_cnt = w_cnt_p2;
                        end
                    end
                    OP_DEREG: begin
                        if (w_dslot_ok) begin
                            n_valid[w_dsl] = 1'b0;
                        end else begin
                            n_res.status = ST_INVALID;
                        end
                    end
                    OP_RES: begin
                        if (w_res_bad) begin
                            n_res.status = ST_INVALID;
                        end
                    end
                    default: begin
                        n_res.status = ST_INVALID;
                    end
                endcase
            end
            S_SCAN: begin
                if (w_issue) begin
                    n_idx     = r_idx + t_scan'(1);
                    n_chk     = 1'b1;
                    n_chk_idx = r_idx[SLOT_W-1:0];
                end
                if (w_free_now) begin
                    n_has_free = 1'b1;
                    n_free     = r_chk_idx;
                end
                if (r_opcode == OP_REG) begin
                    if (w_dup) begin
                        n_res.status = ST_NOSPACE;
                    end else if (w_last && !(r_has_free || w_free_now)) begin
                        n_res.status = ST_NOSPACE;
                    end
                end else begin
                    if (w_hit) begin
                        n_base = w_rd.base;
                        n_mlen = w_rd.len;
                        n_xtgt = w_rd.tgt;
                        if (w_denied) begin
                            n_res.status = ST_DENIED;
                        end
                    end else if (w_last) begin
                        n_res.status = ST_INVALID;
                    end
                end
            end
            S_ARITH: begin
                n_step = t_astep'(r_step + 3'd1);
                case (r_step)
                    AS_OFF:  n_off  = w_alu_rsp.sum;
                    AS_AEND: n_aend = w_alu_rsp.sum;
                    AS_REND: n_rend = w_alu_rsp.sum;
                    default: n_off  = r_off;
                endcase
                if (w_step_fail) begin
                    n_res.status = ST_INVALID;
                end else if (r_step == AS_XLAT) begin
                    n_res.xaddr = w_alu_rsp.sum;
                end
            end
            S_WRITE: begin
                n_valid[r_free] = 1'b1;
                n_res.slot      = 4'(r_free);
                n_res.lkey      = r_lk;
                n_res.rkey      = r_rk;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase

        // Loading the first key also restarts the counter
        if (w_cfg_wr) begin
            n_cnt = {1'b0, i_cfg_data};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_cnt       <= 33'd1;
            r_idx       <= '0;
            r_chk       <= 1'b0;
            r_chk_idx   <= '0;
            r_has_free  <= 1'b0;
            r_free      <= '0;
            r_step      <= AS_OFF;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_chk       <= n_chk;
            r_chk_idx   <= n_chk_idx;
            r_has_free  <= n_has_free;
            r_free      <= n_free;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opcode <= n_opcode;
        r_dom    <= n_dom;
        r_addr   <= n_addr;
        r_len    <= n_len;
        r_tgt    <= n_tgt;
        r_acc    <= n_acc;
        r_key    <= n_key;
        r_remote <= n_remote;
        r_slot   <= n_slot;
        r_lk     <= n_lk;
        r_rk     <= n_rk;
        r_base   <= n_base;
        r_mlen   <= n_mlen;
        r_xtgt   <= n_xtgt;
        r_off    <= n_off;
        r_aend   <= n_aend;
        r_rend   <= n_rend;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out.status;
    assign o_slot_index         = r_out.slot;
    assign o_local_key_out      = r_out.lkey;
    assign o_remote_key_out     = r_out.rkey;
    assign o_translated_address = r_out.xaddr;

    // A table write always claims exactly one free slot
    `MKRT_ASSERT_NEXT(a_write_claims_slot, i_clk, i_rst_n, (r_state == S_WRITE),
        ($countones(r_valid) == $past($countones(r_valid)) + 1))

    // A finished word reaches the output register as soon as it is free
    `MKRT_ASSERT_NEXT(a_done_delivers, i_clk, i_rst_n, ((r_state == S_DONE) && w_out_free),
        ((r_state == S_IDLE) && r_out_valid))

    // The key counter moves only on a config write or in the check step
    `MKRT_ASSERT_NEXT(a_cnt_hold, i_clk, i_rst_n, ((r_state != S_CHECK) && !w_cfg_wr),
        $stable(r_cnt))

    // No new word is taken while one is in the scan or range check steps
    `MKRT_ASSERT_NOW(a_one_in_flight, i_clk, i_rst_n, (r_state == S_SCAN || r_state == S_ARITH),
        !w_accept)

endmodule
